### rtl/jsu_pkg.sv
// Shared types, codes and helper functions for the JSON string unescaper.
`default_nettype none

package jsu_pkg;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_STR    = 4'd1,
        PH_ESC    = 4'd2,
        PH_HEX    = 4'd3,
        PH_HI_BS  = 4'd4,
        PH_HI_U   = 4'd5,
        PH_LO_HEX = 4'd6,
        PH_ERR    = 4'd7,
        PH_DONE   = 4'd8
    } phase_t;

    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_DONE = 2'd1,
        KIND_ERR  = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        ERR_NONE        = 4'd0,
        ERR_NO_QUOTE    = 4'd1,
        ERR_END         = 4'd2,
        ERR_END_ESC     = 4'd3,
        ERR_END_HEX     = 4'd4,
        ERR_BAD_ESC     = 4'd5,
        ERR_BAD_HEX     = 4'd6,
        ERR_NO_LOW_SURR = 4'd7,
        ERR_LONE_LOW    = 4'd8
    } err_t;

    localparam logic [15:0] HIGH_SURR_MIN = 16'hD800;
    localparam logic [15:0] HIGH_SURR_MAX = 16'hDBFF;
    localparam logic [15:0] LOW_SURR_MIN  = 16'hDC00;
    localparam logic [15:0] LOW_SURR_MAX  = 16'hDFFF;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;

    // One group of result words caused by a single input word.
    typedef struct packed {
        logic            has;
        logic [1:0]      last_idx;
        logic [3:0][7:0] bytes;
        kind_t           kind;
        err_t            err;
    } jsu_group_t;

    typedef struct packed {
        logic [1:0]      last_idx;
        logic [3:0][7:0] bytes;
    } utf8_t;

    // Returns {valid, value} for one ASCII hex digit.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    // Encodes a code point as 1 to 4 UTF-8 bytes, first byte in entry 0.
    function automatic utf8_t cp_to_utf8(input logic [20:0] cp);
        utf8_t r;
        r = '0;
        if (cp < 21'h80) begin
            r.last_idx = 2'd0;
            r.bytes[0] = cp[7:0];
        end else if (cp < 21'h800) begin
            r.last_idx = 2'd1;
            r.bytes[0] = {3'b110, cp[10:6]};
            r.bytes[1] = {2'b10, cp[5:0]};
        end else if (cp < 21'h10000) begin
            r.last_idx = 2'd2;
            r.bytes[0] = {4'b1110, cp[15:12]};
            r.bytes[1] = {2'b10, cp[11:6]};
            r.bytes[2] = {2'b10, cp[5:0]};
        end else begin
            r.last_idx = 2'd3;
            r.bytes[0] = {5'b11110, cp[20:18]};
            r.bytes[1] = {2'b10, cp[17:12]};
            r.bytes[2] = {2'b10, cp[11:6]};
            r.bytes[3] = {2'b10, cp[5:0]};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/jsu_decode.sv
// Escape state machine: holds the decode state and forms the result group of one word.
`default_nettype none

module jsu_decode (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 step,
    input  wire  [7:0]          in_byte,
    input  wire                 end_flag,
    output jsu_pkg::jsu_group_t group
);
    import jsu_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [15:0] acc_reg, acc_next;
    logic [15:0] high_reg, high_next;
    logic [1:0]  cnt_reg, cnt_next;

    logic [4:0]  hex;
    logic [15:0] acc_shift;
    logic        is_quote, is_bsl, last_digit;
    logic        is_high, is_low;
    logic [20:0] cp;
    utf8_t       enc;

    assign hex        = hex_digit(in_byte);
    assign acc_shift  = {acc_reg[11:0], hex[3:0]};
    assign is_quote   = !end_flag && in_byte == CH_QUOTE;
    assign is_bsl     = !end_flag && in_byte == CH_BSL;
    assign last_digit = cnt_reg == 2'd3;
    assign is_high    = acc_shift >= HIGH_SURR_MIN && acc_shift <= HIGH_SURR_MAX;
    assign is_low     = acc_shift >= LOW_SURR_MIN && acc_shift <= LOW_SURR_MAX;
    assign cp         = (phase_reg == PH_LO_HEX)
                      ? 21'h10000 + {1'b0, high_reg[9:0], acc_shift[9:0]}
                      : {5'd0, acc_shift};
    assign enc        = cp_to_utf8(cp);

    always_comb begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        high_next  = high_reg;
        cnt_next   = cnt_reg;
        unique case (phase_reg)
            PH_IDLE, PH_DONE, PH_ERR: begin
                if (is_quote) begin
                    phase_next = PH_STR;
                    acc_next   = '0;
                    high_next  = '0;
                    cnt_next   = '0;
                end else if (phase_reg == PH_IDLE
                             || (phase_reg == PH_DONE && !end_flag)) begin
                    phase_next = PH_ERR;
                    acc_next   = '0;
                    cnt_next   = '0;
                end else if (phase_reg == PH_DONE) begin
                    phase_next = PH_IDLE;
                end
            end
            PH_STR: begin
                if (end_flag) begin
                    phase_next = PH_ERR;
                    acc_next   = '0;
                    cnt_next   = '0;
                end else if (is_quote) begin
                    phase_next = PH_DONE;
                end else if (is_bsl) begin
                    phase_next = PH_ESC;
                end
            end
            PH_ESC: begin
                phase_next = PH_STR;
                if (end_flag) begin
                    phase_next = PH_ERR;
                    acc_next   = '0;
                    cnt_next   = '0;
                end else begin
                    case (in_byte) inside
                        CH_QUOTE, CH_BSL, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T: begin
                            phase_next = PH_STR;
                        end
                        CH_U: begin
                            phase_next = PH_HEX;
                            acc_next   = '0;
                            cnt_next   = '0;
                        end
                        default: begin
                            phase_next = PH_ERR;
                            acc_next   = '0;
                            cnt_next   = '0;
                        end
                    endcase
                end
            end
            PH_HEX, PH_LO_HEX: begin
                if (end_flag || !hex[4]) begin
                    phase_next = PH_ERR;
                    acc_next   = '0;
                    cnt_next   = '0;
                end else if (!last_digit) begin
                    acc_next = acc_shift;
                    cnt_next = cnt_reg + 2'd1;
                end else begin
                    acc_next = '0;
                    cnt_next = '0;
                    if (phase_reg == PH_HEX) begin
                        if (is_high) begin
                            high_next  = acc_shift;
                            phase_next = PH_HI_BS;
                        end else if (is_low) begin
                            phase_next = PH_ERR;
                        end else begin
                            phase_next = PH_STR;
                        end
                    end else if (!is_low) begin
                        phase_next = PH_ERR;
                    end else begin
                        high_next  = '0;
                        phase_next = PH_STR;
                    end
                end
            end
            PH_HI_BS: begin
                if (!is_bsl) begin
                    phase_next = PH_ERR;
                    acc_next   = '0;
                    cnt_next   = '0;
                end else begin
                    phase_next = PH_HI_U;
                end
            end
            PH_HI_U: begin
                if (end_flag || in_byte != CH_U) begin
                    phase_next = PH_ERR;
                    acc_next   = '0;
                    cnt_next   = '0;
                end else begin
                    phase_next = PH_LO_HEX;
                    acc_next   = '0;
                    cnt_next   = '0;
                end
            end
            default: begin
                phase_next = PH_ERR;
            end
        endcase
    end

    always_comb begin
        group = '0;
        unique case (phase_reg)
            PH_IDLE, PH_DONE: begin
                if (!is_quote && (phase_reg == PH_IDLE || !end_flag)) begin
                    group.has  = 1'b1;
                    group.kind = KIND_ERR;
                    group.err  = end_flag ? ERR_END : ERR_NO_QUOTE;
                end
            end
            PH_STR: begin
                if (end_flag) begin
                    group.has  = 1'b1;
                    group.kind = KIND_ERR;
                    group.err  = ERR_END;
                end else if (is_quote) begin
                    group.has  = 1'b1;
                    group.kind = KIND_DONE;
                end else if (!is_bsl) begin
                    group.has      = 1'b1;
                    group.bytes[0] = in_byte;
                end
            end
            PH_ESC: begin
                group.has = 1'b1;
                if (end_flag) begin
                    group.kind = KIND_ERR;
                    group.err  = ERR_END_ESC;
                end else begin
                    case (in_byte) inside
                        CH_QUOTE, CH_BSL, CH_SLASH: group.bytes[0] = in_byte;
                        CH_B:    group.bytes[0] = 8'h08;
                        CH_F:    group.bytes[0] = 8'h0C;
                        CH_N:    group.bytes[0] = 8'h0A;
                        CH_R:    group.bytes[0] = 8'h0D;
                        CH_T:    group.bytes[0] = 8'h09;
                        CH_U:    group.has      = 1'b0;
                        default: begin
                            group.kind = KIND_ERR;
                            group.err  = ERR_BAD_ESC;
                        end
                    endcase
                end
            end
            PH_HEX, PH_LO_HEX: begin
                if (end_flag) begin
                    group.has  = 1'b1;
                    group.kind = KIND_ERR;
                    group.err  = ERR_END_HEX;
                end else if (!hex[4]) begin
                    group.has  = 1'b1;
                    group.kind = KIND_ERR;
                    group.err  = ERR_BAD_HEX;
                end else if (last_digit) begin
                    if (phase_reg == PH_HEX && is_low) begin
                        group.has  = 1'b1;
                        group.kind = KIND_ERR;
                        group.err  = ERR_LONE_LOW;
                    end else if (phase_reg == PH_LO_HEX && !is_low) begin
                        group.has  = 1'b1;
                        group.kind = KIND_ERR;
                        group.err  = ERR_NO_LOW_SURR;
                    end else if (!(phase_reg == PH_HEX && is_high)) begin
                        group.has      = 1'b1;
                        group.last_idx = enc.last_idx;
                        group.bytes    = enc.bytes;
                    end
                end
            end
            PH_HI_BS: begin
                if (!is_bsl) begin
                    group.has  = 1'b1;
                    group.kind = KIND_ERR;
                    group.err  = ERR_NO_LOW_SURR;
                end
            end
            PH_HI_U: begin
                if (end_flag || in_byte != CH_U) begin
                    group.has  = 1'b1;
                    group.kind = KIND_ERR;
                    group.err  = ERR_NO_LOW_SURR;
                end
            end
            default: begin
                group = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            acc_reg   <= '0;
            high_reg  <= '0;
            cnt_reg   <= '0;
        end else if (step) begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            high_reg  <= high_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

### rtl/json_string_unescape_top.sv
// Top level of the JSON string unescaper: input register, decoder and result buffer.
// Path: a word is registered at input, decoded combinationally from that register, and its
// result group is captured in the result buffer, from which its words are offered.
// Throughput: one input word per cycle while m_tready is high and each word yields at most
// one result word; a \u escape with a multi-byte UTF-8 result holds the input until its last byte is taken.
// Reset (aresetn low, synchronous) empties both registers and returns to awaiting a quote.
`default_nettype none

module json_string_unescape_top (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // in_byte[7:0]
    input  wire         s_tuser,   // end_flag[0]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata,   // out_byte[7:0], kind[9:8], error_code[13:10], zero[15:14]
    output logic        m_tlast
);
    import jsu_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_end_reg;

    jsu_group_t dec_group;
    jsu_group_t grp_reg;
    logic       grp_valid_reg, grp_valid_next;
    logic [1:0] idx_reg, idx_next;

    logic out_take, out_free, fire, in_take;
    logic at_last;

    assign at_last  = idx_reg == grp_reg.last_idx;
    assign out_take = m_tvalid && m_tready;
    assign out_free = !grp_valid_reg || (m_tready && at_last);
    assign fire     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || fire;
    assign in_take  = s_tvalid && s_tready;

    jsu_decode u_decode (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (fire),
        .in_byte  (in_byte_reg),
        .end_flag (in_end_reg),
        .group    (dec_group)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_take) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        grp_valid_next = grp_valid_reg;
        idx_next       = idx_reg;
        if (fire) begin
            grp_valid_next = dec_group.has;
            idx_next       = '0;
        end else if (out_take) begin
            if (at_last) begin
                grp_valid_next = 1'b0;
            end else begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            grp_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            grp_valid_reg <= grp_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_byte_reg <= s_tdata;
            in_end_reg  <= s_tuser;
        end
        if (fire) begin
            grp_reg <= dec_group;
        end
    end

    assign m_tvalid = grp_valid_reg;
    assign m_tlast  = at_last;
    assign m_tdata  = {2'b00, grp_reg.err, grp_reg.kind,
                       (grp_reg.kind == KIND_BYTE) ? grp_reg.bytes[idx_reg] : 8'h00};

    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        grp_valid_reg |-> idx_reg <= grp_reg.last_idx)
        else $error("result index beyond group end");

    a_multi_is_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        (grp_valid_reg && grp_reg.last_idx != 2'd0) |-> grp_reg.kind == KIND_BYTE)
        else $error("multi-word group that is not data");

    a_err_has_code: assert property (@(posedge aclk) disable iff (!aresetn)
        grp_valid_reg |-> ((grp_reg.kind == KIND_ERR) == (grp_reg.err != ERR_NONE)))
        else $error("error code does not match kind");

    a_held_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !fire) |=> (in_valid_reg && $stable(in_byte_reg)
                                     && $stable(in_end_reg)))
        else $error("pending input word lost");

    a_group_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (grp_valid_reg && !(m_tready && at_last)) |=> grp_valid_reg)
        else $error("result group dropped before delivery");

endmodule

`default_nettype wire
